// ----- design/matmul_transposed_diag_scale_core_defines.svh -----
// Assertion macros used by the checker of the matrix multiply core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MATMUL_TRANSPOSED_DIAG_SCALE_CORE_DEFINES_SVH
`define MATMUL_TRANSPOSED_DIAG_SCALE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mtds_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply core.
// Used by the controller, the datapath, the top level and the checker.
package mtds_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 8;

  // Fixed field widths of the stream items.
  localparam int CMD_W     = 2;
  localparam int IN_IDX_W  = 3;
  localparam int VALUE_W   = 8;
  localparam int RES_W     = 27;
  localparam int DIM_W     = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  localparam int IN_TDATA_W  = ((2 * IN_IDX_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * IN_IDX_W + RES_W + 7) / 8) * 8;

  // Derived storage widths.
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int MAC_W  = (ACC_W > RES_W) ? RES_W : ACC_W;

  typedef enum logic [CMD_W-1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_WR_D    = 2'd2,
    OP_COMPUTE = 2'd3
  } mtds_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_LOAD
  } mtds_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                wr_a;
    logic                wr_b;
    logic                wr_d;
    logic                rd_en;
    logic                clr_acc;
    logic [ADDR_W-1:0]   a_addr;
    logic [ADDR_W-1:0]   b_addr;
    logic [IDX_W-1:0]    d_idx;
    logic                scale_en;
    logic [IN_IDX_W-1:0] tag_row;
    logic [IN_IDX_W-1:0] tag_col;
    logic                tag_last;
    logic                load_out;
  } mtds_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic busy;
    logic out_free;
  } mtds_sts_t;

  // Flat address of element (r, c) in a MAX_DIM x MAX_DIM store.
  function automatic logic [ADDR_W-1:0] elem_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [ADDR_W:0] full;
    full = (ADDR_W + 1)'(r) * (ADDR_W + 1)'(MAX_DIM) + (ADDR_W + 1)'(c);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ----- design/mtds_ctrl.sv -----
// Controller of the matrix multiply core: state machine, dimension register
// and the i, j, k loop counters. Depends on mtds_pkg.
module mtds_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mtds_pkg::DIM_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mtds_pkg::mtds_op_e            in_op_i,
  input  mtds_pkg::mtds_sts_t           sts_i,
  output mtds_pkg::mtds_cmd_t           cmd_o
);

  mtds_pkg::mtds_state_e             state_q, state_d;
  logic [mtds_pkg::DIM_W-1:0]        dim_q;
  logic [mtds_pkg::IDX_W-1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [mtds_pkg::IDX_W-1:0]        n_last;
  logic                              in_fire;
  logic                              last_elem;

  // Zero acts as one, anything above the maximum saturates.
  always_comb begin
    if (dim_q == '0) begin
      n_last = '0;
    end else if (dim_q > mtds_pkg::DIM_W'(mtds_pkg::MAX_DIM)) begin
      n_last = mtds_pkg::IDX_W'(mtds_pkg::MAX_DIM - 1);
    end else begin
      n_last = mtds_pkg::IDX_W'(dim_q - mtds_pkg::DIM_W'(1));
    end
  end

  assign in_ready_o = (state_q == mtds_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_elem  = (i_q == n_last) && (j_q == n_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= mtds_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtds_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    cmd_o          = '0;
    cmd_o.a_addr   = mtds_pkg::elem_addr(i_q, k_q);
    cmd_o.b_addr   = mtds_pkg::elem_addr(j_q, k_q);
    cmd_o.d_idx    = j_q;
    cmd_o.tag_row  = mtds_pkg::IN_IDX_W'(i_q);
    cmd_o.tag_col  = mtds_pkg::IN_IDX_W'(j_q);
    cmd_o.tag_last = last_elem;

    unique case (state_q)
      mtds_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op_i)
            mtds_pkg::OP_WR_A: cmd_o.wr_a = 1'b1;
            mtds_pkg::OP_WR_B: cmd_o.wr_b = 1'b1;
            mtds_pkg::OP_WR_D: cmd_o.wr_d = 1'b1;
            mtds_pkg::OP_COMPUTE: begin
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              state_d = mtds_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      mtds_pkg::ST_READ: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.clr_acc = (k_q == '0);
        if (k_q == n_last) begin
          k_d     = '0;
          state_d = mtds_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + mtds_pkg::IDX_W'(1);
        end
      end
      mtds_pkg::ST_DRAIN: begin
        if (!sts_i.busy) begin
          cmd_o.scale_en = 1'b1;
          state_d        = mtds_pkg::ST_LOAD;
        end
      end
      mtds_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (last_elem) begin
            state_d = mtds_pkg::ST_IDLE;
          end else begin
            state_d = mtds_pkg::ST_READ;
            if (j_q == n_last) begin
              j_d = '0;
              i_d = i_q + mtds_pkg::IDX_W'(1);
            end else begin
              j_d = j_q + mtds_pkg::IDX_W'(1);
            end
          end
        end
      end
      default: state_d = mtds_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/mtds_dp.sv -----
// Datapath of the matrix multiply core: element stores, multiply-accumulate,
// diagonal scaling and the output register. Depends on mtds_pkg.
module mtds_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mtds_pkg::mtds_cmd_t                cmd_i,
  input  logic [mtds_pkg::IN_IDX_W-1:0]      row_i,
  input  logic [mtds_pkg::IN_IDX_W-1:0]      col_i,
  input  logic [mtds_pkg::VALUE_W-1:0]       value_i,
  output mtds_pkg::mtds_sts_t                sts_o,
  input  logic                               m_tready_i,
  output logic                               m_tvalid_o,
  output logic [mtds_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  output logic                               m_tlast_o
);

  localparam int PadW = mtds_pkg::OUT_TDATA_W - 2 * mtds_pkg::IN_IDX_W - mtds_pkg::RES_W;

  logic [mtds_pkg::ELEM_BITS-1:0] mem_a [mtds_pkg::DEPTH];
  logic [mtds_pkg::ELEM_BITS-1:0] mem_b [mtds_pkg::DEPTH];
  logic [mtds_pkg::ELEM_BITS-1:0] mem_d [mtds_pkg::MAX_DIM];

  logic [mtds_pkg::ELEM_BITS-1:0]            a_rd_q, b_rd_q, d_rd_q;
  logic                                      rd_vld_q, mul_vld_q;
  logic [mtds_pkg::PROD_W-1:0]               prod_q;
  logic [mtds_pkg::ACC_W-1:0]                acc_q;
  logic [mtds_pkg::MAC_W-1:0]                acc_trim;
  logic [mtds_pkg::MAC_W+mtds_pkg::ELEM_BITS-1:0] scale_full;
  logic [mtds_pkg::RES_W-1:0]                res_q, out_res_q;
  logic [mtds_pkg::IN_IDX_W-1:0]             res_row_q, res_col_q, out_row_q, out_col_q;
  logic                                      res_last_q, out_last_q, out_vld_q;
  logic                                      in_range, d_in_range;
  logic [mtds_pkg::ADDR_W-1:0]               wr_addr;
  logic [mtds_pkg::ELEM_BITS-1:0]            wr_val;

  // Writes with an index beyond the store are dropped.
  assign d_in_range = ({1'b0, row_i} < (mtds_pkg::IN_IDX_W + 1)'(mtds_pkg::MAX_DIM));
  assign in_range   = d_in_range &&
                      ({1'b0, col_i} < (mtds_pkg::IN_IDX_W + 1)'(mtds_pkg::MAX_DIM));
  assign wr_addr    = mtds_pkg::elem_addr(mtds_pkg::IDX_W'(row_i), mtds_pkg::IDX_W'(col_i));
  assign wr_val     = mtds_pkg::ELEM_BITS'(value_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && in_range) begin
      mem_a[wr_addr] <= wr_val;
    end
    if (cmd_i.wr_b && in_range) begin
      mem_b[wr_addr] <= wr_val;
    end
    if (cmd_i.wr_d && d_in_range) begin
      mem_d[mtds_pkg::IDX_W'(row_i)] <= wr_val;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= mem_a[cmd_i.a_addr];
      b_rd_q <= mem_b[cmd_i.b_addr];
      d_rd_q <= mem_d[cmd_i.d_idx];
    end
  end

  // Multiply, then accumulate the registered product in the next cycle.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + mtds_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      mul_vld_q <= rd_vld_q;
    end
  end

  assign sts_o.busy     = rd_vld_q || mul_vld_q;
  assign sts_o.out_free = !out_vld_q || m_tready_i;

  // The dot product is cut to the smaller of the accumulator and result widths before scaling.
  assign acc_trim   = mtds_pkg::MAC_W'(acc_q);
  assign scale_full = acc_trim * d_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      res_q      <= scale_full[mtds_pkg::RES_W-1:0];
      res_row_q  <= cmd_i.tag_row;
      res_col_q  <= cmd_i.tag_col;
      res_last_q <= cmd_i.tag_last;
    end
    if (cmd_i.load_out) begin
      out_res_q  <= res_q;
      out_row_q  <= res_row_q;
      out_col_q  <= res_col_q;
      out_last_q <= res_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {{PadW{1'b0}}, out_res_q, out_col_q, out_row_q};

endmodule

// ----- design/matmul_transposed_diag_scale_core.sv -----
// Top level of the matrix multiply core with diagonal scaling.
// Depends on mtds_pkg, mtds_ctrl and mtds_dp.
//
// Usage: the input stream carries one command per transfer. tuser selects
// the command (write A, write B, write D, compute) and tdata carries the
// row, column and element value. Writes are accepted back to back while
// the core is idle. A compute transfer starts a run that emits n * n
// result transfers in row-major order, n being dim with zero taken as one
// and values above 8 taken as 8, C[i][j] equal to the dot product of row i
// of A and row j of the stored B, times D[j]; the final one carries tlast.
// Each result element comes from the single shared multiply-accumulate
// unit reading one A and one B element per cycle, then the drain of the
// multiply pipeline, a scaling step and a load of the output register.
// Input tready stays low for the run.
// Reset clears the controller and sets dim to 8; the element stores are
// not cleared and must be written before they are used.
// A stalled output holds its result in the output register; the run
// pauses until the receiver takes it, and nothing is lost.
module matmul_transposed_diag_scale_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: dim register, written when cfg_we_i is high.
  input  logic                              cfg_we_i,
  input  logic [mtds_pkg::DIM_W-1:0]        cfg_wdata_i,
  // Command stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, from bit 0: row[2:0], col[5:3], value[13:6], zero padding.
  input  logic [mtds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: cmd[1:0].
  input  logic [mtds_pkg::CMD_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, from bit 0: out_row[2:0], out_col[5:3], result[32:6], zero padding.
  output logic [mtds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int ColLo = mtds_pkg::IN_IDX_W;
  localparam int ValLo = 2 * mtds_pkg::IN_IDX_W;

  mtds_pkg::mtds_cmd_t cmd;
  mtds_pkg::mtds_sts_t sts;

  mtds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (mtds_pkg::mtds_op_e'(s_axis_tuser)),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mtds_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .row_i      (s_axis_tdata[mtds_pkg::IN_IDX_W-1:0]),
    .col_i      (s_axis_tdata[ColLo +: mtds_pkg::IN_IDX_W]),
    .value_i    (s_axis_tdata[ValLo +: mtds_pkg::VALUE_W]),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ----- design/mtds_checker.sv -----
// Port-level checker for the matrix multiply core, bound to the top level.
// Depends on mtds_pkg and matmul_transposed_diag_scale_core_defines.svh.
`include "matmul_transposed_diag_scale_core_defines.svh"

module mtds_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [mtds_pkg::CMD_W-1:0]        s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mtds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);

  logic compute_fire;

  assign compute_fire = s_axis_tvalid && s_axis_tready &&
                        (s_axis_tuser == mtds_pkg::OP_COMPUTE);

  // A stalled result holds still.
  `MTDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // A compute transfer closes the input for its run.
  `MTDS_ASSERT_NEXT(a_run_blocks, clk_i, rst_ni, compute_fire, !s_axis_tready, "input open right after a compute transfer")

  // The input closes only because a compute transfer was taken.
  `MTDS_ASSERT_NOW(a_close_cause, clk_i, rst_ni, $fell(s_axis_tready), $past(compute_fire), "input closed without a compute transfer")

  // The last element of a run sits on the diagonal.
  `MTDS_ASSERT_NOW(a_last_diag, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2:0] == m_axis_tdata[5:3], "last result not on the diagonal")

endmodule

bind matmul_transposed_diag_scale_core mtds_checker u_mtds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/matmul_transposed_diag_scale_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for matmul_transposed_diag_scale_core: loads the A, B and D stores,
// runs compute commands under random stream gaps and checks every result element in order.
// Depends on mtds_pkg and the core itself.
module matmul_transposed_diag_scale_core_test;

  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 50;
  localparam logic [63:0] RES_MASK = (64'd1 << mtds_pkg::RES_W) - 64'd1;

  typedef struct packed {
    logic [mtds_pkg::IN_IDX_W-1:0] row;
    logic [mtds_pkg::IN_IDX_W-1:0] col;
    logic [mtds_pkg::RES_W-1:0]    value;
    logic                          last;
  } product_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [mtds_pkg::DIM_W-1:0]       cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [mtds_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [mtds_pkg::CMD_W-1:0]       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [mtds_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // Expected products in emission order, and the shadow copy of the core's state.
  product_t                       expected_products[$];
  logic [mtds_pkg::ELEM_BITS-1:0] shadow_a[mtds_pkg::DEPTH];
  logic [mtds_pkg::ELEM_BITS-1:0] shadow_b[mtds_pkg::DEPTH];
  logic [mtds_pkg::ELEM_BITS-1:0] shadow_diag[mtds_pkg::MAX_DIM];
  bit                             a_loaded[mtds_pkg::DEPTH];
  bit                             b_loaded[mtds_pkg::DEPTH];
  bit                             diag_loaded[mtds_pkg::MAX_DIM];
  logic [mtds_pkg::DIM_W-1:0]     shadow_dim;

  int unsigned errors;
  int unsigned items_sent;
  bit          gaps_on;

  matmul_transposed_diag_scale_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A dim of zero acts as one and anything above the store size saturates.
  function automatic int unsigned active_dim();
    if (shadow_dim == '0) return 1;
    if (shadow_dim > mtds_pkg::MAX_DIM) return mtds_pkg::MAX_DIM;
    return int'(shadow_dim);
  endfunction

  // Flat store index of element (r, c).
  function automatic logic [mtds_pkg::ADDR_W-1:0] elem_index(int unsigned r, int unsigned c);
    return mtds_pkg::elem_addr(mtds_pkg::IDX_W'(r), mtds_pkg::IDX_W'(c));
  endfunction

  function automatic void queue_scaled_products();
    int unsigned n;
    logic [63:0] acc;
    product_t    p;
    n = active_dim();
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        acc = '0;
        for (int unsigned k = 0; k < n; k++) begin
          acc += 64'(shadow_a[elem_index(i, k)]) * 64'(shadow_b[elem_index(j, k)]);
        end
        acc     = (acc & RES_MASK) * 64'(shadow_diag[mtds_pkg::IDX_W'(j)]);
        p.row   = mtds_pkg::IN_IDX_W'(i);
        p.col   = mtds_pkg::IN_IDX_W'(j);
        p.value = acc[mtds_pkg::RES_W-1:0];
        p.last  = (i == n - 1) && (j == n - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  function automatic void apply_command(mtds_pkg::mtds_op_e op, logic [2:0] r, logic [2:0] c,
                                        logic [7:0] v);
    case (op)
      mtds_pkg::OP_WR_A: begin
        shadow_a[elem_index(r, c)] = v;
        a_loaded[elem_index(r, c)] = 1'b1;
      end
      mtds_pkg::OP_WR_B: begin
        shadow_b[elem_index(r, c)] = v;
        b_loaded[elem_index(r, c)] = 1'b1;
      end
      mtds_pkg::OP_WR_D: begin
        shadow_diag[mtds_pkg::IDX_W'(r)] = v;
        diag_loaded[mtds_pkg::IDX_W'(r)] = 1'b1;
      end
      default: queue_scaled_products();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, with tvalid
  // still high so that a following item goes out back to back.
  task automatic send_item(mtds_pkg::mtds_op_e op, logic [2:0] r, logic [2:0] c,
                           logic [7:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= mtds_pkg::IN_TDATA_W'({v, c, r});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_command(op, r, c, v);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic release_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain every pending product, then give the core time to settle back to idle.
  task automatic wait_idle();
    release_input();
    while (expected_products.size() != 0) @(negedge clk_i);
    repeat (active_dim() + 8) @(negedge clk_i);
  endtask

  task automatic set_dim(logic [mtds_pkg::DIM_W-1:0] d);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_dim  = d;
  endtask

  // Writes random values into every entry the next compute reads that is still unwritten.
  task automatic load_missing();
    int unsigned n;
    n = active_dim();
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        if (!a_loaded[elem_index(r, c)])
          send_item(mtds_pkg::OP_WR_A, 3'(r), 3'(c), 8'($urandom_range(0, 255)));
        if (!b_loaded[elem_index(r, c)])
          send_item(mtds_pkg::OP_WR_B, 3'(r), 3'(c), 8'($urandom_range(0, 255)));
      end
      if (!diag_loaded[mtds_pkg::IDX_W'(r)])
        send_item(mtds_pkg::OP_WR_D, 3'(r), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
    end
  endtask

  // Compute ignores its index and value fields, so they carry random content.
  task automatic run_compute();
    load_missing();
    send_item(mtds_pkg::OP_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic test_single_element();
    set_dim(4'd1);
    send_item(mtds_pkg::OP_WR_A, 3'd0, 3'd0, 8'hff);
    send_item(mtds_pkg::OP_WR_B, 3'd0, 3'd0, 8'hff);
    send_item(mtds_pkg::OP_WR_D, 3'd0, 3'd7, 8'hff);
    run_compute();
    send_item(mtds_pkg::OP_WR_A, 3'd0, 3'd0, 8'h00);
    run_compute();
  endtask

  task automatic test_dim_zero();
    set_dim(4'd0);
    send_item(mtds_pkg::OP_WR_A, 3'd0, 3'd0, 8'd17);
    send_item(mtds_pkg::OP_WR_B, 3'd0, 3'd0, 8'd3);
    run_compute();
  endtask

  // Dim above the store size saturates to eight; all-ones data gives the largest result.
  task automatic test_full_scale();
    set_dim(4'd15);
    for (int unsigned r = 0; r < mtds_pkg::MAX_DIM; r++) begin
      for (int unsigned c = 0; c < mtds_pkg::MAX_DIM; c++) begin
        send_item(mtds_pkg::OP_WR_A, 3'(r), 3'(c), 8'hff);
        send_item(mtds_pkg::OP_WR_B, 3'(r), 3'(c), 8'hff);
      end
      send_item(mtds_pkg::OP_WR_D, 3'(r), 3'd0, 8'hff);
    end
    run_compute();
  endtask

  // Entries beyond a small dim are stored and must show up once dim grows again.
  task automatic test_unused_indices();
    set_dim(4'd2);
    send_item(mtds_pkg::OP_WR_A, 3'd7, 3'd7, 8'haa);
    send_item(mtds_pkg::OP_WR_B, 3'd7, 3'd0, 8'h55);
    send_item(mtds_pkg::OP_WR_D, 3'd7, 3'd5, 8'h81);
    send_item(mtds_pkg::OP_WR_A, 3'd1, 3'd0, 8'h00);
    send_item(mtds_pkg::OP_WR_B, 3'd0, 3'd1, 8'h01);
    run_compute();
    set_dim(4'd8);
    run_compute();
  endtask

  // Mostly write bursts closed by a compute, with stray writes and dim changes between.
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned burst;
    logic [mtds_pkg::DIM_W-1:0] d;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first > RANDOM_ITEMS * 4 / 5) gaps_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 5) == 0) d = mtds_pkg::DIM_W'($urandom_range(0, 15));
        else d = mtds_pkg::DIM_W'($urandom_range(1, 4));
        set_dim(d);
      end
      burst = $urandom_range(0, 8);
      repeat (burst) begin
        send_item(mtds_pkg::mtds_op_e'(mtds_pkg::CMD_W'($urandom_range(0, 2))),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 5) != 0) run_compute();
    end
    release_input();
  endtask

  // Result stall: random bursts of low tready while gaps are enabled.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  // Each result transfer is compared against the oldest expected product.
  always @(posedge clk_i) begin
    product_t want;
    product_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row   = m_axis_tdata[2:0];
      got.col   = m_axis_tdata[5:3];
      got.value = m_axis_tdata[6 +: mtds_pkg::RES_W];
      got.last  = m_axis_tlast;
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d value %0d last %0b", $time,
                 got.row, got.col, got.value, got.last);
        errors++;
      end else begin
        want = expected_products.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected row %0d col %0d value %0d last %0b", $time,
                   want.row, want.col, want.value, want.last);
          $display("%0t:           actual row %0d col %0d value %0d last %0b", $time,
                   got.row, got.col, got.value, got.last);
          errors++;
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mtds_pkg::OP_WR_A;
    errors        = 0;
    items_sent    = 0;
    gaps_on       = 1'b1;
    shadow_dim    = mtds_pkg::DIM_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_element();
    test_dim_zero();
    test_full_scale();
    test_unused_indices();
    test_random_traffic();
    wait_idle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mtds_pkg.sv
design/mtds_ctrl.sv
design/mtds_dp.sv
design/matmul_transposed_diag_scale_core.sv
design/mtds_checker.sv
tb/matmul_transposed_diag_scale_core_test.sv
